[sv/bbr_pkg.sv]
package bbr_pkg;

  // Frame limits and derived widths.
  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned WidthW    = 11;
  localparam int unsigned HeightW   = 13;
  // The row counter runs two rows past the frame while the last outputs drain.
  localparam int unsigned RowW      = $clog2(MaxHeight + 2);

  localparam int unsigned PixW = 32;
  localparam int unsigned ChW  = 8;
  localparam int unsigned RgbW = 3 * ChW;

  // Sum of nine 8-bit samples, and floor(x / 9) as (x * 3641) >> 15, exact for x < 2296.
  localparam int unsigned SumW        = 12;
  localparam int unsigned ProdW       = 2 * SumW;
  localparam int unsigned Recip9      = 3641;
  localparam int unsigned Recip9Shift = 15;

  localparam logic [ChW-1:0] AlphaOpaque = 8'hFF;

  localparam logic [WidthW-1:0]  WidthReset  = WidthW'(800);
  localparam logic [HeightW-1:0] HeightReset = HeightW'(600);

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = HeightW;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameWidth  = 1'b0,
    CfgFrameHeight = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    CmdPixel = 1'b0,
    CmdFlush = 1'b1
  } cmd_e;

  typedef logic [RgbW-1:0] rgb_t;

  // One line-store entry: the previous row and the row before it.
  typedef struct packed {
    rgb_t prev1;
    rgb_t prev2;
  } line_entry_t;

  // The new window column, top row first.
  typedef struct packed {
    rgb_t top;
    rgb_t mid;
    rgb_t bot;
  } column_t;

  // Per-item control handed from the position logic to the window.
  typedef struct packed {
    logic valid;
    logic emit;
    logic last;
    logic skip_left;
    logic skip_right;
  } win_ctrl_t;

endpackage

[sv/box_blur_3x3_rgb.sv]
// Channel  Direction  Transfer when                      Payload
// s_axis   in         s_axis_tvalid_i & s_axis_tready_o  tdata pixel, tuser flush flag
// m_axis   out        m_axis_tvalid_o & m_axis_tready_i  tdata blurred pixel, tlast frame end
// cfg      in         cfg_valid_i & cfg_ready_o          cfg_index_i register, cfg_data_i value
//
// The block takes one pixel per clock unless the output stalls; its results are registered.
// The rate is set by the single line memory, which is read and written once per pixel.
// Reset clears the position counters and the window and loads the default frame size;
// the line memory is not cleared, since rows are masked by position before use.
// A stall on the output side holds the whole pipeline, and s_axis_tready_o drops with it.
module box_blur_3x3_rgb (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [bbr_pkg::PixW-1:0]     s_axis_tdata_i,   // [31:0] in_pixel
  input  logic                         s_axis_tuser_i,   // [0] cmd
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [bbr_pkg::PixW-1:0]     m_axis_tdata_o,   // [31:0] out_pixel
  output logic                         m_axis_tlast_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bbr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bbr_pkg::CfgDataW-1:0] cfg_data_i
);

  // Per-item state carried into the memory stage.
  typedef struct packed {
    logic valid;
    logic emit;
    logic last;
    logic skip_left;
    logic skip_right;
    logic row_ge1;
    logic row_ge2;
    logic bot_valid;
  } s1_ctrl_t;

  logic [bbr_pkg::WidthW-1:0]  width_q;
  logic [bbr_pkg::HeightW-1:0] height_q;
  logic [bbr_pkg::ColW-1:0]    col_q, col_d;
  logic [bbr_pkg::RowW-1:0]    row_q, row_d;

  s1_ctrl_t                 s1_q, s1_d;
  logic [bbr_pkg::ColW-1:0] s1_addr_q;
  bbr_pkg::rgb_t            s1_rgb_q;

  logic                       adv;
  logic                       take;
  logic                       drop;
  logic                       col_wrap;
  logic                       last_pos;
  logic [bbr_pkg::RowW-1:0]   height_p1;
  logic [bbr_pkg::WidthW-1:0] cfg_width;
  logic [bbr_pkg::HeightW-1:0] cfg_height;

  bbr_pkg::line_entry_t rd_entry;
  bbr_pkg::line_entry_t wr_entry;
  bbr_pkg::column_t     column;
  bbr_pkg::win_ctrl_t   win_ctrl;
  logic                 out_valid;

  // The pipeline moves whenever the output register is free or being emptied.
  assign adv             = !out_valid || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid;

  // A flush tick before the first pixel of a frame is taken and ignored.
  assign drop = (s_axis_tuser_i == bbr_pkg::CmdFlush) && (row_q == '0) && (col_q == '0);
  assign take = s_axis_tvalid_i && adv && !drop;

  assign height_p1 = bbr_pkg::RowW'(height_q) + bbr_pkg::RowW'(1);
  assign col_wrap  = (bbr_pkg::WidthW'(col_q) + bbr_pkg::WidthW'(1)) == width_q;
  // The last output of a frame falls on the first column, two rows past the frame.
  assign last_pos  = (row_q == height_p1) && (col_q == '0);

  // Out-of-range sizes clamp to 1 and to the maximum.
  always_comb begin
    cfg_width  = cfg_data_i[bbr_pkg::WidthW-1:0];
    cfg_height = cfg_data_i[bbr_pkg::HeightW-1:0];
    if (cfg_width == '0) begin
      cfg_width = bbr_pkg::WidthW'(1);
    end else if (cfg_width > bbr_pkg::WidthW'(bbr_pkg::MaxWidth)) begin
      cfg_width = bbr_pkg::WidthW'(bbr_pkg::MaxWidth);
    end
    if (cfg_height == '0) begin
      cfg_height = bbr_pkg::HeightW'(1);
    end else if (cfg_height > bbr_pkg::HeightW'(bbr_pkg::MaxHeight)) begin
      cfg_height = bbr_pkg::HeightW'(bbr_pkg::MaxHeight);
    end
  end

  // Raster position of the next input, with a restart after the frame's last output.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (take) begin
      if (last_pos) begin
        col_d = '0;
        row_d = '0;
      end else if (col_wrap) begin
        col_d = '0;
        row_d = row_q + bbr_pkg::RowW'(1);
      end else begin
        col_d = col_q + bbr_pkg::ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bbr_pkg::WidthReset;
      height_q <= bbr_pkg::HeightReset;
      col_q    <= '0;
      row_q    <= '0;
    end else if (cfg_valid_i) begin
      // Any register write abandons the frame in progress.
      case (cfg_index_i)
        bbr_pkg::CfgFrameWidth:  width_q  <= cfg_width;
        bbr_pkg::CfgFrameHeight: height_q <= cfg_height;
        default: ;
      endcase
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Control for the item entering the memory stage. The left neighbor lies outside the
  // frame when the output column is 0, the right one when it is the last column.
  always_comb begin
    s1_d            = '0;
    s1_d.valid      = take;
    s1_d.emit       = (row_q >= bbr_pkg::RowW'(2)) || ((row_q == bbr_pkg::RowW'(1)) && (col_q != '0));
    s1_d.last       = last_pos;
    s1_d.skip_left  = (col_q == bbr_pkg::ColW'(1)) ||
                      ((col_q == '0) && (width_q == bbr_pkg::WidthW'(1)));
    s1_d.skip_right = (col_q == '0);
    s1_d.row_ge1    = (row_q >= bbr_pkg::RowW'(1));
    s1_d.row_ge2    = (row_q >= bbr_pkg::RowW'(2));
    s1_d.bot_valid  = (s_axis_tuser_i == bbr_pkg::CmdPixel) &&
                      (bbr_pkg::HeightW'(row_q) < height_q) &&
                      (row_q < bbr_pkg::RowW'(height_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else if (adv) begin
      s1_q <= s1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_addr_q <= col_q;
      s1_rgb_q  <= s_axis_tdata_i[bbr_pkg::PixW-1 -: bbr_pkg::RgbW];
    end
  end

  // Rows above the frame read as zero, as do rows and pixels past its end.
  always_comb begin
    column.top     = s1_q.row_ge2   ? rd_entry.prev2 : '0;
    column.mid     = s1_q.row_ge1   ? rd_entry.prev1 : '0;
    column.bot     = s1_q.bot_valid ? s1_rgb_q       : '0;
    wr_entry.prev1 = column.bot;
    wr_entry.prev2 = column.mid;
  end

  always_comb begin
    win_ctrl.valid      = s1_q.valid;
    win_ctrl.emit       = s1_q.emit;
    win_ctrl.last       = s1_q.last;
    win_ctrl.skip_left  = s1_q.skip_left;
    win_ctrl.skip_right = s1_q.skip_right;
  end

  bbr_line_mem u_line_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (adv && s1_q.valid),
    .waddr_i (s1_addr_q),
    .wdata_i (wr_entry),
    .re_i    (take),
    .raddr_i (col_q),
    .rdata_o (rd_entry)
  );

  bbr_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .ctrl_i      (win_ctrl),
    .col_i       (column),
    .out_valid_o (out_valid),
    .out_pixel_o (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

`ifndef SYNTHESIS
  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bbr_pkg::WidthW'(col_q) < width_q)
    else $error("column position outside the frame width");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= height_p1)
    else $error("row position past the drain row");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && last_pos) |=> ((col_q == '0) && (row_q == '0)))
    else $error("position not restarted after the frame's last output");
`endif

endmodule

[sv/bbr_line_mem.sv]
module bbr_line_mem (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    we_i,
  input  logic [bbr_pkg::ColW-1:0] waddr_i,
  input  bbr_pkg::line_entry_t    wdata_i,
  input  logic                    re_i,
  input  logic [bbr_pkg::ColW-1:0] raddr_i,
  output bbr_pkg::line_entry_t    rdata_o
);

  bbr_pkg::line_entry_t mem_q [bbr_pkg::MaxWidth];
  bbr_pkg::line_entry_t rdata_q;
  bbr_pkg::line_entry_t byp_q;
  logic                 byp_sel_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
      byp_q   <= wdata_i;
    end
  end

  // A read that meets a write to the same entry takes the new data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_sel_q <= 1'b0;
    end else if (re_i) begin
      byp_sel_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = byp_sel_q ? byp_q : rdata_q;

endmodule

[sv/bbr_window.sv]
module bbr_window (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  bbr_pkg::win_ctrl_t       ctrl_i,
  input  bbr_pkg::column_t         col_i,
  output logic                     out_valid_o,
  output logic [bbr_pkg::PixW-1:0] out_pixel_o,
  output logic                     out_last_o
);

  // win_q[row][col]: row 0 is the top row, col 2 the newest column.
  bbr_pkg::rgb_t      win_q [3][3];
  bbr_pkg::win_ctrl_t s2_d;
  bbr_pkg::win_ctrl_t s2_q;

  logic [bbr_pkg::SumW-1:0]  sum_d [3];
  logic [bbr_pkg::SumW-1:0]  sum_q [3];
  logic                      s3_valid_q;
  logic                      s3_last_q;
  logic [bbr_pkg::ProdW-1:0] prod [3];
  logic [bbr_pkg::ChW-1:0]   quo [3];

  logic                     out_valid_q;
  logic [bbr_pkg::PixW-1:0] out_pixel_q;
  logic                     out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (adv_i && ctrl_i.valid) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= col_i.top;
      win_q[1][2] <= col_i.mid;
      win_q[2][2] <= col_i.bot;
    end
  end

  // Only items that release a pixel stay valid past the window.
  always_comb begin
    s2_d       = ctrl_i;
    s2_d.valid = ctrl_i.valid && ctrl_i.emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q        <= '0;
      s3_valid_q  <= 1'b0;
      s3_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else if (adv_i) begin
      s2_q        <= s2_d;
      s3_valid_q  <= s2_q.valid;
      s3_last_q   <= s2_q.last;
      out_valid_q <= s3_valid_q;
      out_last_q  <= s3_last_q;
    end
  end

  // Columns outside the frame are left out of the sum.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_d[ch] = '0;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (!((c == 0) && s2_q.skip_left) && !((c == 2) && s2_q.skip_right)) begin
          for (int ch = 0; ch < 3; ch++) begin
            sum_d[ch] = sum_d[ch]
                      + bbr_pkg::SumW'(win_q[r][c][ch*bbr_pkg::ChW +: bbr_pkg::ChW]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sum_q       <= sum_d;
      out_pixel_q <= {quo[2], quo[1], quo[0], bbr_pkg::AlphaOpaque};
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = bbr_pkg::ProdW'(sum_q[ch]) * bbr_pkg::ProdW'(bbr_pkg::Recip9);
      quo[ch]  = prod[ch][bbr_pkg::Recip9Shift +: bbr_pkg::ChW];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pixel_o = out_pixel_q;
  assign out_last_o  = out_last_q;

endmodule
